### rtl/core/lab_pkg.sv
// Package with the shared types and constants of the buffer offset allocator.
package lab_pkg;

    localparam int MaxBuffersDef = 64;
    localparam int SizeW = 24;
    localparam int StepW = 16;
    localparam int OfsW = 31;
    localparam logic [OfsW-1:0] OfsMax = {OfsW{1'b1}};

    // One table entry as held in the memory.
    localparam int EntW = OfsW + SizeW + 2 * StepW;

    typedef struct packed {
        logic             begin_plan;
        logic [SizeW-1:0] buffer_size;
        logic [StepW-1:0] first_step;
        logic [StepW-1:0] last_step;
    } t_in;

    typedef struct packed {
        logic [OfsW-1:0] placed_offset;
        logic [OfsW-1:0] required_total;
        logic            table_full;
    } t_out;

    typedef struct packed {
        logic [OfsW-1:0]  ofs;
        logic [SizeW-1:0] size;
        logic [StepW-1:0] first;
        logic [StepW-1:0] last;
    } t_ent;

endpackage

### rtl/core/lab_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module lab_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/lifetime_aware_buffer_offset_allocator.sv
// Top level of the lifetime-aware buffer offset allocator.
// A zero-size buffer goes straight to the result with offset zero; otherwise the N stored
// entries are scanned, one read per cycle, the offset and total are settled, and then a
// shift pass moves entries up to insert the new one in offset order unless the table is full.
// One buffer is worked at a time; the input waits until the result transfer is taken.
// Reset empties the table and zeroes the total; the memory keeps its contents.
module lifetime_aware_buffer_offset_allocator
    import lab_pkg::*;
#(
    parameter int MAX_BUFFERS = MaxBuffersDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);
    localparam int AW = $clog2(MAX_BUFFERS);
    localparam int CW = $clog2(MAX_BUFFERS + 1);
    localparam logic [CW-1:0] CntMax = CW'(MAX_BUFFERS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DONE  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [OfsW-1:0]  r_total, n_total;
    t_in              r_in;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_rd_v, n_rd_v;
    logic [OfsW:0]    r_cursor, n_cursor;
    logic [OfsW:0]    r_best, n_best;
    logic [OfsW:0]    r_gap, n_gap;
    logic             r_have, n_have;
    logic [OfsW-1:0]  r_ofs, n_ofs;
    t_out             r_out, n_out;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    t_ent             wdata, rdata;
    logic [OfsW:0]    so, end_v, fit;
    logic             overlap;
    logic [OfsW:0]    cand;
    logic [OfsW:0]    tsum;
    logic [OfsW-1:0]  tsat;

    lab_ram #(.Width(EntW), .Depth(MAX_BUFFERS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

    always_comb begin
        so      = {1'b0, rdata.ofs};
        end_v   = so + (OfsW+1)'(rdata.size);
        fit     = r_cursor + (OfsW+1)'(r_in.buffer_size);
        overlap = !(rdata.last < r_in.first_step || rdata.first > r_in.last_step);
        cand    = r_have ? r_best : r_cursor;
        tsum    = {1'b0, r_ofs} + (OfsW+1)'(r_in.buffer_size);
        tsat    = tsum[OfsW] ? OfsMax : tsum[OfsW-1:0];
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_total  = r_total;
        n_idx    = r_idx;
        n_rd_v   = 1'b0;
        n_cursor = r_cursor;
        n_best   = r_best;
        n_gap    = r_gap;
        n_have   = r_have;
        n_ofs    = r_ofs;
        n_out    = r_out;
        we       = 1'b0;
        waddr    = r_idx[AW-1:0];
        wdata    = rdata;
        raddr    = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_count  = i_data.begin_plan ? '0 : r_count;
                    n_total  = i_data.begin_plan ? '0 : r_total;
                    n_cursor = '0;
                    n_have   = 1'b0;
                    n_idx    = '0;
                    if (i_data.buffer_size == '0) begin
                        n_out.placed_offset  = '0;
                        n_out.required_total = n_total;
                        n_out.table_full     = 1'b0;
                        n_state              = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Issue reads while entries remain; evaluate the entry read last cycle.
                if (r_idx < r_count) begin
                    n_rd_v = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
                if (r_rd_v && overlap) begin
                    if (fit <= so && (!r_have || (so - r_cursor) < r_gap)) begin
                        n_have = 1'b1;
                        n_best = r_cursor;
                        n_gap  = so - r_cursor;
                    end
                    if (end_v > r_cursor) begin
                        n_cursor = end_v;
                    end
                end
                if (!(r_idx < r_count) && !r_rd_v) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_ofs   = cand[OfsW] ? OfsMax : cand[OfsW-1:0];
                n_state = S_WAIT;
                n_idx   = r_count;
            end
            S_WAIT: begin
                if (tsat > r_total) begin
                    n_total = tsat;
                end
                n_out.placed_offset = r_ofs;
                n_out.table_full    = (r_count >= CntMax);
                n_out.required_total = (tsat > r_total) ? tsat : r_total;
                if (r_count >= CntMax) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SHIFT;
                    n_rd_v  = 1'b0;
                end
            end
            S_SHIFT: begin
                // Walk down from the top: read entry idx-1, then move it up or insert.
                if (!r_rd_v) begin
                    if (r_idx == '0) begin
                        we      = 1'b1;
                        waddr   = '0;
                        wdata   = '{r_ofs, r_in.buffer_size, r_in.first_step,
                                    r_in.last_step};
                        n_count = r_count + 1'b1;
                        n_state = S_OUT;
                    end else begin
                        raddr  = AW'(r_idx - 1'b1);
                        n_rd_v = 1'b1;
                    end
                end else begin
                    if (rdata.ofs > r_ofs) begin
                        we    = 1'b1;
                        waddr = r_idx[AW-1:0];
                        n_idx = r_idx - 1'b1;
                    end else begin
                        we      = 1'b1;
                        waddr   = r_idx[AW-1:0];
                        wdata   = '{r_ofs, r_in.buffer_size, r_in.first_step,
                                    r_in.last_step};
                        n_count = r_count + 1'b1;
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_SCAN) begin
            raddr = r_idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_rd_v  <= n_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_in <= i_data;
        end
        r_idx    <= n_idx;
        r_cursor <= n_cursor;
        r_best   <= n_best;
        r_gap    <= n_gap;
        r_have   <= n_have;
        r_ofs    <= n_ofs;
        r_out    <= n_out;
    end
endmodule
